// File: src/mftm_pkg.sv
// Shared types and constants of the motor fault timer monitor.
// Field widths, flag bit positions, register map and per-channel state record.
// No dependencies.
package mftm_pkg;

    localparam int ADC_W  = 12;
    localparam int TIME_W = 16;
    localparam int SUM_W  = 16;
    localparam int FLAG_W = 4;
    localparam int CH_W   = 1;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // flag and pending bit positions
    localparam int FLAG_LOAD  = 0;
    localparam int FLAG_CUR   = 1;
    localparam int FLAG_OVER  = 2;
    localparam int FLAG_UNDER = 3;

    typedef enum logic [2:0] {
        REG_STALL_THRESHOLD   = 3'd0,
        REG_OVERCURRENT_LEVEL = 3'd1,
        REG_TRIP_TIME         = 3'd2,
        REG_RECOVERY_TIME     = 3'd3,
        REG_MAX_VOLTAGE       = 3'd4,
        REG_MIN_VOLTAGE       = 3'd5,
        REG_VOLTAGE_DEBOUNCE  = 3'd6
    } reg_idx_t;

    localparam logic [ADC_W-1:0]  RST_STALL_THRESHOLD   = 12'd2976;
    localparam logic [ADC_W-1:0]  RST_OVERCURRENT_LEVEL = 12'd4095;
    localparam logic [TIME_W-1:0] RST_TRIP_TIME         = 16'd500;
    localparam logic [TIME_W-1:0] RST_RECOVERY_TIME     = 16'd3000;
    localparam logic [ADC_W-1:0]  RST_MAX_VOLTAGE       = 12'd0;
    localparam logic [ADC_W-1:0]  RST_MIN_VOLTAGE       = 12'd0;
    localparam logic [TIME_W-1:0] RST_VOLTAGE_DEBOUNCE  = 16'd500;

    typedef struct packed {
        logic [ADC_W-1:0]  last_current;
        logic [SUM_W-1:0]  delta_sum;
        logic [FLAG_W-1:0] pending;
        logic [FLAG_W-1:0] flags;
        logic [TIME_W-1:0] load_trip_cnt;
        logic [TIME_W-1:0] load_recover_cnt;
        logic [TIME_W-1:0] cur_trip_cnt;
        logic [TIME_W-1:0] cur_recover_cnt;
        logic [TIME_W-1:0] overvolt_cnt;
        logic [TIME_W-1:0] undervolt_cnt;
    } ch_state_t;

    // one latched or following flag after a tick
    typedef struct packed {
        logic              flag;
        logic [TIME_W-1:0] trip_cnt;
        logic [TIME_W-1:0] recover_cnt;
    } flag_step_t;

endpackage

// File: src/motor_fault_timer_monitor_core.sv
// Motor fault timer monitor: per-channel overload, overcurrent and voltage flags.
// Single-pass datapath between an input register and a result register.
// Depends on mftm_pkg.
//
//  Port group     Direction  Handshake           Payload
//  --------------------------------------------------------------------------------
//  item input     in         in_valid/in_ready   kind, channel, current_sample,
//                                                 voltage_sample
//  flag result    out        out_valid/out_ready overload, overcurrent, overvoltage,
//                                                 undervoltage
//  configuration  in/out     APB, pready = 1     paddr, pwdata, prdata
//
// One item per clock while results are taken; each accepted request is held in the
// input register, then its result is loaded into the result register. Channel state
// updates at the edge that loads the result register, so the next item already sees
// it.
// rst_n clears all channel state and restores the register reset values.
// A stalled result holds the result register; the input register still takes one
// request, after which in_ready drops until the result moves on.
module motor_fault_timer_monitor_core #(
    parameter int CHANNELS = 2
) (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         kind,
    input  logic [mftm_pkg::CH_W-1:0]    channel,
    input  logic [mftm_pkg::ADC_W-1:0]   current_sample,
    input  logic [mftm_pkg::ADC_W-1:0]   voltage_sample,

    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         overload,
    output logic                         overcurrent,
    output logic                         overvoltage,
    output logic                         undervoltage,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mftm_pkg::ADDR_W-1:0]  paddr,
    input  logic [mftm_pkg::DATA_W-1:0]  pwdata,
    output logic [mftm_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);

    localparam int ADC_W  = mftm_pkg::ADC_W;
    localparam int TIME_W = mftm_pkg::TIME_W;
    localparam int SUM_W  = mftm_pkg::SUM_W;
    localparam int FLAG_W = mftm_pkg::FLAG_W;
    localparam int CH_W   = mftm_pkg::CH_W;
    localparam int DATA_W = mftm_pkg::DATA_W;

    // configuration registers
    logic [ADC_W-1:0]  stall_threshold_reg;
    logic [ADC_W-1:0]  overcurrent_level_reg;
    logic [TIME_W-1:0] trip_time_reg;
    logic [TIME_W-1:0] recovery_time_reg;
    logic [ADC_W-1:0]  max_voltage_reg;
    logic [ADC_W-1:0]  min_voltage_reg;
    logic [TIME_W-1:0] voltage_debounce_reg;

    mftm_pkg::reg_idx_t cfg_idx;
    logic               cfg_write;

    // input register
    logic              in_valid_reg;
    logic              kind_reg;
    logic [CH_W-1:0]   channel_reg;
    logic [ADC_W-1:0]  current_reg;
    logic [ADC_W-1:0]  voltage_reg;

    // result register
    logic              out_valid_reg;
    logic [FLAG_W-1:0] flags_out_reg;
    logic [FLAG_W-1:0] flags_out_next;

    mftm_pkg::ch_state_t ch_state_reg [CHANNELS];
    mftm_pkg::ch_state_t cur_st;
    mftm_pkg::ch_state_t ch_state_next;

    logic advance;
    logic in_range;

    logic signed [ADC_W:0]   diff;
    logic signed [SUM_W+1:0] sum_wide;
    logic [SUM_W-1:0]        sum_sat;
    logic                    load_pend;
    logic                    volt_enable;
    mftm_pkg::flag_step_t    load_step;
    mftm_pkg::flag_step_t    cur_step;
    mftm_pkg::flag_step_t    over_step;
    mftm_pkg::flag_step_t    under_step;

    // trip after trip_t ticks of pending, then auto-clear after rec_t ticks
    function automatic mftm_pkg::flag_step_t latch_step(
        input logic              pend,
        input logic              flag,
        input logic [TIME_W-1:0] trip_cnt,
        input logic [TIME_W-1:0] rec_cnt,
        input logic [TIME_W-1:0] trip_t,
        input logic [TIME_W-1:0] rec_t
    );
        mftm_pkg::flag_step_t r;
        logic [TIME_W:0]      trip_inc;
        logic [TIME_W:0]      rec_inc;
        r.flag        = flag;
        r.trip_cnt    = trip_cnt;
        r.recover_cnt = rec_cnt;
        trip_inc      = {1'b0, trip_cnt} + {{TIME_W{1'b0}}, 1'b1};
        if (pend) begin
            if (trip_inc >= {1'b0, trip_t}) begin
                r.trip_cnt = '0;
                r.flag     = 1'b1;
            end else begin
                r.trip_cnt = trip_inc[TIME_W-1:0];
            end
        end else begin
            r.trip_cnt = '0;
        end
        rec_inc = {1'b0, rec_cnt} + {{TIME_W{1'b0}}, 1'b1};
        // a flag that trips on this tick counts the same tick toward recovery
        if (r.flag) begin
            if (rec_inc >= {1'b0, rec_t}) begin
                r.recover_cnt = '0;
                r.flag        = 1'b0;
            end else begin
                r.recover_cnt = rec_inc[TIME_W-1:0];
            end
        end
        return r;
    endfunction

    // set after the debounce time, drop at once when the condition goes away
    function automatic mftm_pkg::flag_step_t follow_step(
        input logic              pend,
        input logic              flag,
        input logic [TIME_W-1:0] cnt,
        input logic [TIME_W-1:0] deb_t
    );
        mftm_pkg::flag_step_t r;
        logic [TIME_W:0]      cnt_inc;
        r.flag        = flag;
        r.trip_cnt    = cnt;
        r.recover_cnt = '0;
        cnt_inc       = {1'b0, cnt} + {{TIME_W{1'b0}}, 1'b1};
        if (pend) begin
            if (cnt_inc >= {1'b0, deb_t}) begin
                r.trip_cnt = '0;
                r.flag     = 1'b1;
            end else begin
                r.trip_cnt = cnt_inc[TIME_W-1:0];
            end
        end else begin
            r.trip_cnt = '0;
            r.flag     = 1'b0;
        end
        return r;
    endfunction

    //--------------------------------------------------------------------------
    // configuration port
    //--------------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_idx   = mftm_pkg::reg_idx_t'(paddr[mftm_pkg::ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_threshold_reg   <= mftm_pkg::RST_STALL_THRESHOLD;
            overcurrent_level_reg <= mftm_pkg::RST_OVERCURRENT_LEVEL;
            trip_time_reg         <= mftm_pkg::RST_TRIP_TIME;
            recovery_time_reg     <= mftm_pkg::RST_RECOVERY_TIME;
            max_voltage_reg       <= mftm_pkg::RST_MAX_VOLTAGE;
            min_voltage_reg       <= mftm_pkg::RST_MIN_VOLTAGE;
            voltage_debounce_reg  <= mftm_pkg::RST_VOLTAGE_DEBOUNCE;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                mftm_pkg::REG_STALL_THRESHOLD:   stall_threshold_reg   <= pwdata[ADC_W-1:0];
                mftm_pkg::REG_OVERCURRENT_LEVEL: overcurrent_level_reg <= pwdata[ADC_W-1:0];
                mftm_pkg::REG_TRIP_TIME:         trip_time_reg         <= pwdata[TIME_W-1:0];
                mftm_pkg::REG_RECOVERY_TIME:     recovery_time_reg     <= pwdata[TIME_W-1:0];
                mftm_pkg::REG_MAX_VOLTAGE:       max_voltage_reg       <= pwdata[ADC_W-1:0];
                mftm_pkg::REG_MIN_VOLTAGE:       min_voltage_reg       <= pwdata[ADC_W-1:0];
                mftm_pkg::REG_VOLTAGE_DEBOUNCE:  voltage_debounce_reg  <= pwdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            mftm_pkg::REG_STALL_THRESHOLD:
                prdata = {{(DATA_W-ADC_W){1'b0}}, stall_threshold_reg};
            mftm_pkg::REG_OVERCURRENT_LEVEL:
                prdata = {{(DATA_W-ADC_W){1'b0}}, overcurrent_level_reg};
            mftm_pkg::REG_TRIP_TIME:
                prdata = {{(DATA_W-TIME_W){1'b0}}, trip_time_reg};
            mftm_pkg::REG_RECOVERY_TIME:
                prdata = {{(DATA_W-TIME_W){1'b0}}, recovery_time_reg};
            mftm_pkg::REG_MAX_VOLTAGE:
                prdata = {{(DATA_W-ADC_W){1'b0}}, max_voltage_reg};
            mftm_pkg::REG_MIN_VOLTAGE:
                prdata = {{(DATA_W-ADC_W){1'b0}}, min_voltage_reg};
            mftm_pkg::REG_VOLTAGE_DEBOUNCE:
                prdata = {{(DATA_W-TIME_W){1'b0}}, voltage_debounce_reg};
            default:
                prdata = '0;
        endcase
    end

    //--------------------------------------------------------------------------
    // handshake
    //--------------------------------------------------------------------------
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    assign out_valid    = out_valid_reg;
    assign overload     = flags_out_reg[mftm_pkg::FLAG_LOAD];
    assign overcurrent  = flags_out_reg[mftm_pkg::FLAG_CUR];
    assign overvoltage  = flags_out_reg[mftm_pkg::FLAG_OVER];
    assign undervoltage = flags_out_reg[mftm_pkg::FLAG_UNDER];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            kind_reg    <= kind;
            channel_reg <= channel;
            current_reg <= current_sample;
            voltage_reg <= voltage_sample;
        end
        if (advance)
        begin
            flags_out_reg <= flags_out_next;
        end
    end

    //--------------------------------------------------------------------------
    // per-item update
    //--------------------------------------------------------------------------
    assign in_range    = (int'(channel_reg) < CHANNELS);
    assign volt_enable = (max_voltage_reg != '0) && (min_voltage_reg != '0);

    always_comb
    begin
        cur_st = in_range ? ch_state_reg[channel_reg] : '0;

        // saturating running sum of current changes
        diff     = $signed({1'b0, current_reg}) - $signed({1'b0, cur_st.last_current});
        sum_wide = $signed({{2{cur_st.delta_sum[SUM_W-1]}}, cur_st.delta_sum})
                   + $signed({{(SUM_W+1-ADC_W){diff[ADC_W]}}, diff});
        if (sum_wide > $signed((SUM_W+2)'(2 ** (SUM_W-1) - 1)))
        begin
            sum_sat = {1'b0, {(SUM_W-1){1'b1}}};
        end
        else if (sum_wide < -$signed((SUM_W+2)'(2 ** (SUM_W-1))))
        begin
            sum_sat = {1'b1, {(SUM_W-1){1'b0}}};
        end
        else
        begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
        load_pend = !sum_sat[SUM_W-1] && (sum_sat != '0)
                    && (sum_sat >= {{(SUM_W-ADC_W){1'b0}}, stall_threshold_reg});

        load_step  = latch_step(cur_st.pending[mftm_pkg::FLAG_LOAD],
                                cur_st.flags[mftm_pkg::FLAG_LOAD],
                                cur_st.load_trip_cnt, cur_st.load_recover_cnt,
                                trip_time_reg, recovery_time_reg);
        cur_step   = latch_step(cur_st.pending[mftm_pkg::FLAG_CUR],
                                cur_st.flags[mftm_pkg::FLAG_CUR],
                                cur_st.cur_trip_cnt, cur_st.cur_recover_cnt,
                                trip_time_reg, recovery_time_reg);
        over_step  = follow_step(cur_st.pending[mftm_pkg::FLAG_OVER],
                                 cur_st.flags[mftm_pkg::FLAG_OVER],
                                 cur_st.overvolt_cnt, voltage_debounce_reg);
        under_step = follow_step(cur_st.pending[mftm_pkg::FLAG_UNDER],
                                 cur_st.flags[mftm_pkg::FLAG_UNDER],
                                 cur_st.undervolt_cnt, voltage_debounce_reg);

        ch_state_next = cur_st;
        if (!kind_reg)
        begin
            ch_state_next.delta_sum    = sum_sat;
            ch_state_next.last_current = current_reg;
            ch_state_next.pending[mftm_pkg::FLAG_LOAD] = load_pend;
            ch_state_next.pending[mftm_pkg::FLAG_CUR]  = (current_reg >= overcurrent_level_reg);
            // both limits must be set, else hold the voltage conditions
            if (volt_enable)
            begin
                ch_state_next.pending[mftm_pkg::FLAG_OVER]  = (voltage_reg >= max_voltage_reg);
                ch_state_next.pending[mftm_pkg::FLAG_UNDER] = (voltage_reg <= min_voltage_reg);
            end
        end
        else
        begin
            ch_state_next.flags[mftm_pkg::FLAG_LOAD]  = load_step.flag;
            ch_state_next.load_trip_cnt               = load_step.trip_cnt;
            ch_state_next.load_recover_cnt            = load_step.recover_cnt;
            ch_state_next.flags[mftm_pkg::FLAG_CUR]   = cur_step.flag;
            ch_state_next.cur_trip_cnt                = cur_step.trip_cnt;
            ch_state_next.cur_recover_cnt             = cur_step.recover_cnt;
            ch_state_next.flags[mftm_pkg::FLAG_OVER]  = over_step.flag;
            ch_state_next.overvolt_cnt                = over_step.trip_cnt;
            ch_state_next.flags[mftm_pkg::FLAG_UNDER] = under_step.flag;
            ch_state_next.undervolt_cnt               = under_step.trip_cnt;
        end

        flags_out_next = in_range ? ch_state_next.flags : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                ch_state_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                if (advance && in_range && (int'(channel_reg) == i))
                begin
                    ch_state_reg[i] <= ch_state_next;
                end
            end
        end
    end

    //--------------------------------------------------------------------------
    // assertions
    //--------------------------------------------------------------------------
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (in_valid_reg && out_valid_reg && !out_ready))
        else $error("in_ready low without a stalled result");

    a_advance_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed request did not produce a result");

    a_result_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(flags_out_reg)))
        else $error("stalled result changed");

    for (genvar g = 0; g < CHANNELS; g++)
    begin : g_cnt_chk
        // counters wrap to zero on reaching their limit, so all-ones is never stored
        a_cnt_below_max: assert property (@(posedge clk) disable iff (!rst_n)
            (ch_state_reg[g].load_trip_cnt != '1) && (ch_state_reg[g].cur_trip_cnt != '1)
            && (ch_state_reg[g].load_recover_cnt != '1)
            && (ch_state_reg[g].cur_recover_cnt != '1)
            && (ch_state_reg[g].overvolt_cnt != '1) && (ch_state_reg[g].undervolt_cnt != '1))
            else $error("debounce counter reached all ones");
    end

endmodule
